### rtl/core/ffsp_pkg.sv
// Package for the first-fit segment placer: item modes, status codes, page rounding.
// No dependencies.
package ffsp_pkg;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_ANY   = 2'd1;
    localparam logic [1:0] MODE_AT    = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_ROOM  = 2'd1;
    localparam logic [1:0] ST_SEG_FULL = 2'd2;
    localparam logic [1:0] ST_RGN_FULL = 2'd3;

    typedef logic [63:0] t_addr;

    // round up to a page, wrapping at 64 bits
    function automatic t_addr page_up(input t_addr n, input logic [4:0] s);
        t_addr m;
        m = (n - 64'd1) >> s;
        return (m + 64'd1) << s;
    endfunction

endpackage

### rtl/core/ffsp_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module ffsp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/core/first_fit_segment_placer.sv
// First-fit segment placer: a region table and a segment table in RAM,
// a sequencer that walks both. Depends on ffsp_pkg and ffsp_ram.
//
// One item at a time: busy rises on the cycle after start and falls when the
// single result strobes. Load and clear go straight to the done state. Place-at
// reads each region scanned, then each segment. Place-anywhere reads, per region
// tried, the region and then each segment per collision check, with up to
// seg_count+1 checks per region; every step costs one RAM read of a table
// entry. The receiver cannot stall; each result is shown for one cycle on
// o_done.
module first_fit_segment_placer
    import ffsp_pkg::*;
#(
    parameter int REGIONS  = 128,
    parameter int SEGMENTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [63:0] i_region_base,
    input  logic [63:0] i_region_length,
    input  logic        i_region_is_ram,
    input  logic [63:0] i_segment_size,
    input  logic [63:0] i_fixed_addr,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [63:0] o_placed_addr
);
    localparam int RAW = (REGIONS  > 1) ? $clog2(REGIONS)  : 1;
    localparam int SAW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int RCW = $clog2(REGIONS + 1);
    localparam int SCW = $clog2(SEGMENTS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RRD  = 3'd1; // region read issued
    localparam logic [2:0] S_RCHK = 3'd2; // region data back
    localparam logic [2:0] S_SRD  = 3'd3; // segment read issued
    localparam logic [2:0] S_SCHK = 3'd4; // segment data back
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]     r_state;
    logic [4:0]     r_shift;
    logic [RCW-1:0] r_rcnt;
    logic [SCW-1:0] r_scnt;
    logic [1:0]     r_mode;
    t_addr          r_size, r_fixed, r_start, r_limit;
    logic [RCW-1:0] r_ri;
    logic [SCW-1:0] r_si;
    logic [SCW-1:0] r_jumps;
    logic [1:0]     r_status;
    t_addr          r_addr;

    logic             rg_we, sg_we;
    logic [RAW-1:0]   rg_waddr, rg_raddr;
    logic [SAW-1:0]   sg_waddr, sg_raddr;
    t_addr            rg_wb, rg_wl, sg_wb, sg_wl;
    t_addr            rg_b, rg_l, sg_b, sg_l;

    ffsp_ram #(.WIDTH(64), .DEPTH(REGIONS)) u_rbase (
        .i_clk, .i_we(rg_we), .i_waddr(rg_waddr), .i_wdata(rg_wb),
        .i_raddr(rg_raddr), .o_rdata(rg_b));
    ffsp_ram #(.WIDTH(64), .DEPTH(REGIONS)) u_rlen (
        .i_clk, .i_we(rg_we), .i_waddr(rg_waddr), .i_wdata(rg_wl),
        .i_raddr(rg_raddr), .o_rdata(rg_l));
    ffsp_ram #(.WIDTH(64), .DEPTH(SEGMENTS)) u_sbase (
        .i_clk, .i_we(sg_we), .i_waddr(sg_waddr), .i_wdata(sg_wb),
        .i_raddr(sg_raddr), .o_rdata(sg_b));
    ffsp_ram #(.WIDTH(64), .DEPTH(SEGMENTS)) u_slen (
        .i_clk, .i_we(sg_we), .i_waddr(sg_waddr), .i_wdata(sg_wl),
        .i_raddr(sg_raddr), .o_rdata(sg_l));

    logic  accept;
    t_addr rend, sg_end, seg_end_pu, rstart_pu;
    logic  hit;

    assign accept   = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign rg_raddr = r_ri[RAW-1:0];
    assign sg_raddr = r_si[SAW-1:0];

    assign rg_we    = accept && (i_mode == MODE_LOAD) && i_region_is_ram
                      && (r_rcnt < RCW'(REGIONS));
    assign rg_waddr = r_rcnt[RAW-1:0];
    assign rg_wb    = i_region_base;
    assign rg_wl    = i_region_length;

    assign sg_we    = (r_state == S_DONE) && (r_status == ST_OK)
                      && (r_mode != MODE_LOAD) && (r_mode != MODE_CLEAR)
                      && (r_scnt < SCW'(SEGMENTS));
    assign sg_waddr = r_scnt[SAW-1:0];
    assign sg_wb    = r_addr;
    assign sg_wl    = r_size;

    assign rend       = rg_b + rg_l;
    assign rstart_pu  = page_up(rg_b, r_shift);
    assign sg_end     = sg_b + sg_l;
    assign seg_end_pu = page_up(sg_end, r_shift);
    // place-at treats a segment starting right at the range end as a hit
    always_comb begin
        if (r_mode == MODE_AT) begin
            hit = !((r_start + r_size < sg_b) || (r_start >= sg_end));
        end else begin
            hit = !((r_start + r_size <= sg_b) || (r_start >= sg_end));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_shift <= 5'd12;
            r_rcnt  <= '0;
            r_scnt  <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_cfg_we) begin
                r_shift <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_mode   <= i_mode;
                        r_size   <= page_up(i_segment_size, r_shift);
                        r_fixed  <= i_fixed_addr;
                        r_ri     <= '0;
                        r_status <= ST_OK;
                        r_addr   <= '0;
                        unique case (i_mode)
                            MODE_LOAD: begin
                                if (i_region_is_ram) begin
                                    if (r_rcnt < RCW'(REGIONS)) begin
                                        r_rcnt <= r_rcnt + 1'b1;
                                    end else begin
                                        r_status <= ST_RGN_FULL;
                                    end
                                end
                                r_state <= S_DONE;
                            end
                            MODE_CLEAR: begin
                                r_rcnt  <= '0;
                                r_scnt  <= '0;
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_status <= ST_NO_ROOM;
                                r_state  <= (r_rcnt == '0) ? S_DONE : S_RRD;
                            end
                        endcase
                    end
                end
                S_RRD: r_state <= S_RCHK;
                S_RCHK: begin
                    r_si    <= '0;
                    r_jumps <= '0;
                    r_limit <= rend;
                    if (r_mode == MODE_AT) begin
                        r_start <= r_fixed;
                        if ((rg_b <= r_fixed) && (rend >= r_fixed + r_size)) begin
                            r_state <= (r_scnt == '0) ? S_DONE : S_SRD;
                            if (r_scnt == '0) begin
                                r_status <= ST_OK;
                                r_addr   <= r_fixed;
                            end
                        end else if (r_ri + 1'b1 >= r_rcnt) begin
                            r_state <= S_DONE;
                        end else begin
                            r_ri    <= r_ri + 1'b1;
                            r_state <= S_RRD;
                        end
                    end else begin
                        r_start <= rstart_pu;
                        if (rstart_pu + r_size > rend) begin
                            if (r_ri + 1'b1 >= r_rcnt) begin
                                r_state <= S_DONE;
                            end else begin
                                r_ri    <= r_ri + 1'b1;
                                r_state <= S_RRD;
                            end
                        end else if (r_scnt == '0) begin
                            r_status <= ST_OK;
                            r_addr   <= rstart_pu;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_SRD;
                        end
                    end
                end
                S_SRD: r_state <= S_SCHK;
                S_SCHK: begin
                    if (hit) begin
                        if (r_mode == MODE_AT || r_jumps >= r_scnt) begin
                            // collision with no retry: next region or give up
                            if (r_mode == MODE_AT || r_ri + 1'b1 >= r_rcnt) begin
                                r_state <= S_DONE;
                            end else begin
                                r_ri    <= r_ri + 1'b1;
                                r_state <= S_RRD;
                            end
                        end else begin
                            r_jumps <= r_jumps + 1'b1;
                            r_start <= seg_end_pu;
                            r_si    <= '0;
                            if (seg_end_pu + r_size > r_limit) begin
                                if (r_ri + 1'b1 >= r_rcnt) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_ri    <= r_ri + 1'b1;
                                    r_state <= S_RRD;
                                end
                            end else begin
                                r_state <= S_SRD;
                            end
                        end
                    end else if (r_si + 1'b1 >= r_scnt) begin
                        r_status <= ST_OK;
                        r_addr   <= r_start;
                        r_state  <= S_DONE;
                    end else begin
                        r_si    <= r_si + 1'b1;
                        r_state <= S_SRD;
                    end
                end
                S_DONE: begin
                    o_done  <= 1'b1;
                    o_status <= r_status;
                    o_placed_addr <= r_addr;
                    if (sg_we) begin
                        r_scnt <= r_scnt + 1'b1;
                    end
                    // segment table full only once room was found
                    if ((r_status == ST_OK) && (r_mode == MODE_ANY || r_mode == MODE_AT)
                        && (r_scnt >= SCW'(SEGMENTS))) begin
                        o_status      <= ST_SEG_FULL;
                        o_placed_addr <= '0;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### tb/sv/first_fit_segment_placer_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for first_fit_segment_placer: random and directed items,
// predicted by an in-bench table model. Depends on ffsp_pkg and the placer RTL.
module first_fit_segment_placer_test;
    import ffsp_pkg::*;

    localparam int NREG = 128;
    localparam int NSEG = 16;
    localparam int CYCLE_LIMIT = 40000000;

    typedef enum logic [1:0] {K_ITEM, K_CFG, K_DRAIN} t_kind;
    typedef struct {
        t_kind       kind;
        logic [1:0]  mode;
        logic [63:0] rbase;
        logic [63:0] rlen;
        logic        is_ram;
        logic [63:0] size;
        logic [63:0] fixed;
        logic [4:0]  shift;
    } t_req;
    typedef struct {
        logic [1:0]  status;
        logic [63:0] addr;
    } t_placement;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [4:0]  i_cfg_data = 0;
    logic        start = 0;
    logic        busy;
    logic [1:0]  i_mode = 0;
    logic [63:0] i_region_base = 0, i_region_length = 0, i_segment_size = 0, i_fixed_addr = 0;
    logic        i_region_is_ram = 0;
    logic        o_done;
    logic [1:0]  o_status;
    logic [63:0] o_placed_addr;

    first_fit_segment_placer dut (.*);

    initial forever #2 i_clk = ~i_clk;

    t_req       pending[$];
    t_placement placements_due[$];
    int n_items, n_results, n_fail, n_cfg;
    int status_seen[4];

    // predictor state
    logic [63:0] rgn_base[NREG], rgn_len[NREG];
    logic [63:0] seg_start[NSEG], seg_len[NSEG];
    int          rgn_cnt, seg_cnt;
    logic [4:0]  cur_shift = 5'd12;

    function automatic logic [63:0] round_page(logic [63:0] n);
        return (((n - 64'd1) >> cur_shift) + 64'd1) << cur_shift;
    endfunction

    function automatic int overlap_index(logic [63:0] s, logic [63:0] sz, bit touch);
        logic [63:0] e, se;
        bit clear_below;
        e = s + sz;
        for (int j = 0; j < seg_cnt; j++) begin
            se = seg_start[j] + seg_len[j];
            clear_below = touch ? (e < seg_start[j]) : (e <= seg_start[j]);
            if (!(clear_below || s >= se)) return j;
        end
        return -1;
    endfunction

    function automatic bit first_fit(logic [63:0] sz, output logic [63:0] where);
        logic [63:0] lim, s;
        int hit, jumps;
        where = 0;
        for (int i = 0; i < rgn_cnt; i++) begin
            lim = rgn_base[i] + rgn_len[i];
            s = round_page(rgn_base[i]);
            jumps = 0;
            forever begin
                if (s + sz > lim) break;
                hit = overlap_index(s, sz, 0);
                if (hit < 0) begin
                    where = s;
                    return 1;
                end
                if (jumps >= seg_cnt) break;
                jumps++;
                s = round_page(seg_start[hit] + seg_len[hit]);
            end
        end
        return 0;
    endfunction

    function automatic logic [1:0] record_segment(logic [63:0] s, logic [63:0] sz);
        if (seg_cnt >= NSEG) return ST_SEG_FULL;
        seg_start[seg_cnt] = s;
        seg_len[seg_cnt] = round_page(sz);
        seg_cnt++;
        return ST_OK;
    endfunction

    function automatic t_placement place_item(t_req r);
        t_placement p;
        logic [63:0] sz, where;
        p.status = ST_OK;
        p.addr = 0;
        sz = round_page(r.size);
        case (r.mode)
            MODE_LOAD: begin
                if (r.is_ram) begin
                    if (rgn_cnt >= NREG) p.status = ST_RGN_FULL;
                    else begin
                        rgn_base[rgn_cnt] = r.rbase;
                        rgn_len[rgn_cnt] = r.rlen;
                        rgn_cnt++;
                    end
                end
            end
            MODE_ANY: begin
                if (!first_fit(sz, where)) p.status = ST_NO_ROOM;
                else begin
                    p.status = record_segment(where, sz);
                    if (p.status == ST_OK) p.addr = where;
                end
            end
            MODE_AT: begin
                p.status = ST_NO_ROOM;
                for (int i = 0; i < rgn_cnt; i++) begin
                    if (rgn_base[i] <= r.fixed && rgn_base[i] + rgn_len[i] >= r.fixed + sz) begin
                        if (overlap_index(r.fixed, sz, 1) < 0) begin
                            p.status = record_segment(r.fixed, sz);
                            if (p.status == ST_OK) p.addr = r.fixed;
                        end
                        break;
                    end
                end
            end
            default: begin
                rgn_cnt = 0;
                seg_cnt = 0;
            end
        endcase
        return p;
    endfunction

    // ---------------- stimulus building ----------------
    logic [4:0]  gen_shift = 5'd12;
    logic [63:0] gen_bases[$];

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic push_item(logic [1:0] m, logic [63:0] b, logic [63:0] l, logic ram,
                             logic [63:0] sz, logic [63:0] fx);
        t_req r;
        r.kind = K_ITEM; r.mode = m; r.rbase = b; r.rlen = l; r.is_ram = ram;
        r.size = sz; r.fixed = fx; r.shift = 0;
        pending.push_back(r);
        n_items++;
    endtask

    task automatic push_ctl(t_kind k, logic [4:0] v);
        t_req r;
        r.kind = k; r.mode = 0; r.rbase = 0; r.rlen = 0; r.is_ram = 0;
        r.size = 0; r.fixed = 0; r.shift = v;
        if (k == K_CFG) gen_shift = v;
        pending.push_back(r);
    endtask

    task automatic build_phase(bit fill_regions);
        logic [63:0] pg, b, sz;
        int nr, np, pick;
        pg = 64'd1 << gen_shift;
        gen_bases.delete();
        push_item(MODE_CLEAR, rand64(), rand64(), 1'($urandom_range(0, 1)), rand64(), rand64());
        nr = fill_regions ? NREG + 2 : $urandom_range(1, 6);
        for (int i = 0; i < nr; i++) begin
            if ($urandom_range(0, 9) == 0) b = rand64();
            else b = 64'($urandom_range(0, 4096)) * pg + ($urandom_range(0, 5) == 0 ? 64'd7 : 64'd0);
            if ($urandom_range(0, 15) == 0) b = -(pg * 64'($urandom_range(1, 4)));
            gen_bases.push_back(b);
            push_item(MODE_LOAD, b, pg * 64'($urandom_range(1, 40)) + 64'($urandom_range(0, 3)),
                      ($urandom_range(0, 7) != 0), rand64(), rand64());
        end
        np = fill_regions ? 3 : $urandom_range(5, 24);
        for (int i = 0; i < np; i++) begin
            pick = $urandom_range(0, 19);
            case ($urandom_range(0, 7))
                0: sz = rand64();
                1: sz = -64'($urandom_range(0, 3));
                default: sz = pg * 64'($urandom_range(0, 6)) - 64'($urandom_range(0, 1));
            endcase
            if (pick < 11)
                push_item(MODE_ANY, rand64(), rand64(), 1'($urandom_range(0, 1)), sz, rand64());
            else if (pick < 18)
                push_item(MODE_AT, rand64(), rand64(), 1'($urandom_range(0, 1)), sz,
                          gen_bases[$urandom_range(0, gen_bases.size() - 1)]
                          + pg * 64'($urandom_range(0, 30)));
            else
                push_item(2'($urandom_range(0, 3)), rand64(), rand64(),
                          1'($urandom_range(0, 1)), rand64(), rand64());
            if ($urandom_range(0, 60) == 0) push_ctl(K_DRAIN, 0);
        end
    endtask

    // ---------------- driver ----------------
    int gap, settle;
    always @(posedge i_clk) begin : drive
        logic   nstart, nwe, took;
        t_req   r;
        nstart = start;
        nwe = 0;
        took = 0;
        if (i_rst_n) begin
            if (start && !busy) begin
                took = 1;
                placements_due.push_back(place_item('{K_ITEM, i_mode, i_region_base,
                    i_region_length, i_region_is_ram, i_segment_size, i_fixed_addr, 5'd0}));
                nstart = 0;
            end
            if (!nstart) begin
                if (gap > 0) gap--;
                else if (pending.size() > 0) begin
                    r = pending[0];
                    if (r.kind == K_ITEM) begin
                        void'(pending.pop_front());
                        i_mode <= r.mode;
                        i_region_base <= r.rbase;
                        i_region_length <= r.rlen;
                        i_region_is_ram <= r.is_ram;
                        i_segment_size <= r.size;
                        i_fixed_addr <= r.fixed;
                        nstart = 1;
                        gap = ($urandom_range(0, 3) != 0) ? 0 :
                              ($urandom_range(0, 9) == 0 ? $urandom_range(20, 80)
                                                         : $urandom_range(1, 4));
                    end else if (!took && !busy && placements_due.size() == 0) begin
                        if (settle < 4) settle++;
                        else begin
                            settle = 0;
                            void'(pending.pop_front());
                            if (r.kind == K_CFG) begin
                                nwe = 1;
                                i_cfg_data <= r.shift;
                                cur_shift = r.shift;
                                n_cfg++;
                            end
                        end
                    end
                end
            end
        end
        start <= nstart;
        i_cfg_we <= nwe;
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin : watch
        t_placement p;
        if (i_rst_n && o_done) begin
            n_results++;
            status_seen[o_status]++;
            if (placements_due.size() == 0) begin
                $display("%0t: unexpected result status=%0d addr=%h", $time, o_status,
                         o_placed_addr);
                n_fail++;
            end else begin
                p = placements_due.pop_front();
                if (p.status !== o_status || p.addr !== o_placed_addr) begin
                    $display("%0t: mismatch expected status=%0d addr=%h actual status=%0d addr=%h",
                             $time, p.status, p.addr, o_status, o_placed_addr);
                    n_fail++;
                end
            end
        end
    end

    int cycles;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", placements_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [4:0] shifts[$];
        // directed: empty tables, wrapping regions, rounding extremes, touching place-at
        push_item(MODE_ANY, 0, 0, 0, 64'h1000, 0);
        push_item(MODE_AT, 0, 0, 0, 64'h1000, 64'h1000);
        push_item(MODE_LOAD, 64'h1000, 64'h10000, 0, 0, 0);
        push_item(MODE_LOAD, 64'h1000, 64'h10000, 1, 0, 0);
        push_item(MODE_LOAD, 64'hFFFF_FFFF_FFFF_F000, 64'h2000, 1, 0, 0);
        push_item(MODE_LOAD, 64'h123, 64'h8000, 1, 0, 0);
        push_item(MODE_ANY, 0, 0, 0, 64'd0, 0);
        push_item(MODE_ANY, 0, 0, 0, 64'd1, 0);
        push_item(MODE_ANY, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        push_item(MODE_ANY, 0, 0, 0, 64'h3001, 0);
        push_item(MODE_AT, 0, 0, 0, 64'h1000, 64'h1000);
        push_item(MODE_AT, 0, 0, 0, 64'h1000, 64'h9000);
        push_item(MODE_AT, 0, 0, 0, 64'h2000, 64'h7000);
        push_item(MODE_AT, 0, 0, 0, 64'h1000, 64'hFFFF_FFFF_FFFF_FFFF);
        push_item(MODE_AT, 0, 0, 0, 64'h1000, 64'hFFFF_FFFF_FFFF_F000);
        push_item(MODE_ANY, 0, 0, 0, 64'h20000, 0);
        push_item(MODE_CLEAR, 0, 0, 0, 0, 0);
        push_item(MODE_ANY, 0, 0, 0, 64'h1, 0);
        shifts = '{5'd0, 5'd20, 5'd31, 5'd12};
        foreach (shifts[k]) begin
            push_ctl(K_CFG, shifts[k]);
            build_phase(0);
        end
        build_phase(1);
        while (n_items < 1900) begin
            if ($urandom_range(0, 3) == 0)
                push_ctl(K_CFG, ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                                             : 5'($urandom_range(8, 14)));
            build_phase(0);
        end
        push_ctl(K_CFG, 5'd20);
        build_phase(0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        while (pending.size() > 0 || start || busy || placements_due.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("%0d items, %0d page_shift writes", n_items, n_cfg);
        $display("status ok/no-room/seg-full/rgn-full: %0d/%0d/%0d/%0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (n_fail == 0 && placements_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
